// ----- src/osgsd_pkg.sv -----
// ----------------------------------------------------------------------------
// osgsd_pkg: shared types for the o2 sensor short-to-ground diagnosis
// request and result payloads, configuration bundle and counter constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package osgsd_pkg;

    // both diagnosis counters saturate at this value
    localparam logic [15:0] CNT_CAP = 16'd52428;
    // effective filter gain ceiling
    localparam logic [7:0] GAIN_CAP = 8'd255;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef struct packed {
        logic [15:0] sensor_voltage;
        logic [15:0] emission_sum;
        logic [7:0]  coolant_temp;
        logic        auto_fuel_active;
        logic        engine_stable;
        logic        vehicle_running;
        logic        inhibit_ground_diag;
        logic        inhibit_electrical_diag;
    } sample_t;

    typedef struct packed {
        logic [15:0] filtered_voltage;
        logic        fault_detected;
        logic        monitor_ran;
    } result_t;

    typedef struct packed {
        logic [7:0]  filter_gain;
        logic [15:0] gas_flow_delay;
        logic [15:0] low_voltage_threshold;
        logic [15:0] emission_limit;
        logic [7:0]  coolant_min;
        logic [15:0] confirm_delay;
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/osgsd_cfg.sv -----
// ----------------------------------------------------------------------------
// osgsd_cfg: configuration register file
// apb-style write and read access to the six diagnosis settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osgsd_cfg
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [osgsd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [osgsd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [osgsd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output osgsd_pkg::cfg_t                          cfg
);

    typedef enum logic [2:0] {
        REG_FILTER_GAIN   = 3'd0,
        REG_GAS_DELAY     = 3'd1,
        REG_LOW_THRESHOLD = 3'd2,
        REG_EMISSION_LIM  = 3'd3,
        REG_COOLANT_MIN   = 3'd4,
        REG_CONFIRM_DELAY = 3'd5
    } reg_index_t;

    osgsd_pkg::cfg_t cfg_reg;
    osgsd_pkg::cfg_t cfg_next;
    logic [2:0]      index;
    logic            wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_FILTER_GAIN:   cfg_next.filter_gain           = pwdata[7:0];
                REG_GAS_DELAY:     cfg_next.gas_flow_delay        = pwdata[15:0];
                REG_LOW_THRESHOLD: cfg_next.low_voltage_threshold = pwdata[15:0];
                REG_EMISSION_LIM:  cfg_next.emission_limit        = pwdata[15:0];
                REG_COOLANT_MIN:   cfg_next.coolant_min           = pwdata[7:0];
                REG_CONFIRM_DELAY: cfg_next.confirm_delay         = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_FILTER_GAIN:   prdata = {24'd0, cfg_reg.filter_gain};
            REG_GAS_DELAY:     prdata = {16'd0, cfg_reg.gas_flow_delay};
            REG_LOW_THRESHOLD: prdata = {16'd0, cfg_reg.low_voltage_threshold};
            REG_EMISSION_LIM:  prdata = {16'd0, cfg_reg.emission_limit};
            REG_COOLANT_MIN:   prdata = {24'd0, cfg_reg.coolant_min};
            REG_CONFIRM_DELAY: prdata = {16'd0, cfg_reg.confirm_delay};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_gain           <= 8'd0;
            cfg_reg.gas_flow_delay        <= osgsd_pkg::CNT_CAP;
            cfg_reg.low_voltage_threshold <= 16'd0;
            cfg_reg.emission_limit        <= 16'hFFFF;
            cfg_reg.coolant_min           <= 8'd0;
            cfg_reg.confirm_delay         <= osgsd_pkg::CNT_CAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/osgsd_filter.sv -----
// ----------------------------------------------------------------------------
// osgsd_filter: first-order low-pass update
// moves the 16.16 filter memory toward the new sample by g/256 of the gap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osgsd_filter
(
    input  wire logic [31:0] mem,
    input  wire logic [15:0] sample_voltage,
    input  wire logic [7:0]  gain,
    output logic      [31:0] mem_next
);

    logic [31:0] target;
    logic        rising;
    logic [31:0] gap;
    logic [7:0]  g;
    logic [39:0] product;
    logic [31:0] delta;

    assign target = {sample_voltage, 16'd0};
    assign rising = (target >= mem);
    assign gap    = rising ? (target - mem) : (mem - target);
    // gain + 1, saturating
    assign g      = (gain == osgsd_pkg::GAIN_CAP) ? osgsd_pkg::GAIN_CAP : (gain + 8'd1);

    assign product = {8'd0, gap} * {32'd0, g};
    assign delta   = product[39:8];

    // delta never exceeds the gap, so neither direction wraps
    assign mem_next = rising ? (mem + delta) : (mem - delta);

endmodule

`default_nettype wire

// ----- src/oxygen_sensor_ground_short_diag_unit.sv -----
// ----------------------------------------------------------------------------
// oxygen_sensor_ground_short_diag_unit: o2 sensor short-to-ground diagnosis
// filters the upstream sensor voltage and confirms a short to ground
// ----------------------------------------------------------------------------
// usage
//   sample channel (sample_valid / sample_stall / sample) carries one tick:
//   raw voltage plus engine conditions. result channel (result_valid /
//   result_stall / result) returns one result per request, in order.
//   a request is first taken into the input register and then moved into
//   the result register, where result_valid rises; a stall can hold it.
//   one request per cycle while the receiver does not stall; the filter
//   update, both counters and the fault decision all resolve in
//   one combinational pass between the input register and the result reg.
//   when the receiver stalls, the pending result holds and one more request
//   is taken into the input register; only then does sample_stall rise.
//   reset clears the filter memory, loads both counters with the cap, sets
//   the default settings and drops requests in flight. the user is to write
//   settings over the apb port only with no request in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oxygen_sensor_ground_short_diag_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                sample_valid,
    output logic                                     sample_stall,
    input  wire osgsd_pkg::sample_t                  sample,
    // result channel
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output osgsd_pkg::result_t                       result,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [osgsd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [osgsd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [osgsd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    // countdown outcome: new count and expiry flag
    typedef struct packed {
        logic [15:0] count;
        logic        expired;
    } cnt_step_t;

    // saturating countdown; expires on reaching zero and stays there
    function automatic cnt_step_t count_down(input logic [15:0] cnt);
        cnt_step_t r;
        if (cnt > osgsd_pkg::CNT_CAP)
        begin
            r.count   = osgsd_pkg::CNT_CAP;
            r.expired = 1'b0;
        end
        else if (cnt > 16'd1)
        begin
            r.count   = cnt - 16'd1;
            r.expired = 1'b0;
        end
        else
        begin
            r.count   = 16'd0;
            r.expired = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [15:0] cap_reload(input logic [15:0] v);
        return (v > osgsd_pkg::CNT_CAP) ? osgsd_pkg::CNT_CAP : v;
    endfunction

    osgsd_pkg::cfg_t    cfg;

    // input register
    logic               s1_valid_reg;
    osgsd_pkg::sample_t s1_data_reg;

    // result register
    logic               out_valid_reg;
    osgsd_pkg::result_t out_data_reg;

    // diagnosis state
    logic [31:0]        filt_mem_reg;
    logic [31:0]        filt_mem_next;
    logic [15:0]        gas_cnt_reg;
    logic [15:0]        gas_cnt_next;
    logic [15:0]        conf_cnt_reg;
    logic [15:0]        conf_cnt_next;
    osgsd_pkg::result_t out_data_next;

    logic               advance;
    cnt_step_t          gas_step;
    cnt_step_t          conf_step;
    logic               gas_enable;
    logic               gas_elapsed;
    logic [15:0]        filt;
    logic               volt_low;
    logic               diag_enable;

    osgsd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    osgsd_filter u_filter
    (
        .mem            (filt_mem_reg),
        .sample_voltage (s1_data_reg.sensor_voltage),
        .gain           (cfg.filter_gain),
        .mem_next       (filt_mem_next)
    );

    // handshake: input register moves on whenever the result slot is free
    assign advance      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && out_valid_reg && result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // gas transport delay
    assign gas_enable  = s1_data_reg.auto_fuel_active && s1_data_reg.vehicle_running;
    assign gas_step    = count_down(gas_cnt_reg);
    assign gas_elapsed = gas_enable && gas_step.expired;
    assign gas_cnt_next = gas_enable ? gas_step.count : cap_reload(cfg.gas_flow_delay);

    // low voltage check on the freshly updated filter output
    assign filt     = filt_mem_next[31:16];
    assign volt_low = (filt < cfg.low_voltage_threshold);

    assign diag_enable = gas_elapsed
                      && s1_data_reg.engine_stable
                      && (s1_data_reg.emission_sum <= cfg.emission_limit)
                      && !s1_data_reg.inhibit_ground_diag
                      && (s1_data_reg.coolant_temp > cfg.coolant_min);

    assign conf_step = count_down(conf_cnt_reg);

    always_comb
    begin
        out_data_next.filtered_voltage = filt;
        out_data_next.fault_detected   = 1'b0;
        out_data_next.monitor_ran      = 1'b0;
        conf_cnt_next                  = cap_reload(cfg.confirm_delay);
        if (volt_low)
        begin
            if (diag_enable)
            begin
                conf_cnt_next = conf_step.count;
                // confirmed short, unless electrical diagnosis is inhibited
                if (conf_step.expired && !s1_data_reg.inhibit_electrical_diag)
                begin
                    out_data_next.fault_detected = 1'b1;
                    out_data_next.monitor_ran    = 1'b1;
                end
            end
        end
        else
        begin
            // voltage plausible: pass verdict
            out_data_next.monitor_ran = !s1_data_reg.inhibit_electrical_diag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filt_mem_reg  <= 32'd0;
            gas_cnt_reg   <= osgsd_pkg::CNT_CAP;
            conf_cnt_reg  <= osgsd_pkg::CNT_CAP;
        end
        else
        begin
            if (!sample_stall)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                filt_mem_reg  <= filt_mem_next;
                gas_cnt_reg   <= gas_cnt_next;
                conf_cnt_reg  <= conf_cnt_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
        begin
            s1_data_reg <= sample;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/osgsd_checker.sv -----
// ----------------------------------------------------------------------------
// osgsd_checker: port-level checks for the diagnosis unit
// flow control and latency seen from the request and result channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osgsd_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               sample_valid,
    input wire logic               sample_stall,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire osgsd_pkg::result_t result
);

    // a stalled result stays and holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

    // an empty result slot never backs up the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !sample_stall)
    else $error("request stalled while result slot empty");

    // requests are only held back by a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
    else $error("request stalled without result backpressure");

    // a fresh result traces back to an accepted request that went through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && !sample_stall, 2))
    else $error("result appeared without a matching request");

endmodule

bind oxygen_sensor_ground_short_diag_unit osgsd_checker u_osgsd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
